FILE: sv/vector_register_element_access_assert.svh
// assertion macros shared by the checker
`ifndef VECTOR_REGISTER_ELEMENT_ACCESS_ASSERT_SVH
`define VECTOR_REGISTER_ELEMENT_ACCESS_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define VREA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define VREA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vrea_pkg.sv
package vrea_pkg;

    localparam int VLEN_BITS_DEFAULT = 128;
    localparam int NUM_REGS          = 32;

    localparam logic [1:0] MODE_RD_ELEM = 2'd0;
    localparam logic [1:0] MODE_WR_ELEM = 2'd1;
    localparam logic [1:0] MODE_RD_MASK = 2'd2;
    localparam logic [1:0] MODE_WR_MASK = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISALIGN = 2'd1;
    localparam logic [1:0] STATUS_RESERVED = 2'd2;
    localparam logic [1:0] STATUS_PAST_END = 2'd3;

    localparam logic [2:0] GMUL_RESERVED = 3'd4;

    localparam logic [1:0] EW_8  = 2'd0;
    localparam logic [1:0] EW_16 = 2'd1;
    localparam logic [1:0] EW_32 = 2'd2;
    localparam logic [1:0] EW_64 = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  reg_num;
        logic [6:0]  elem_index;
        logic [1:0]  elem_width;
        logic [2:0]  group_mul;
        logic        sign_extend;
        logic        check_align;
        logic [63:0] write_data;
    } req_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic [1:0]  status;
    } rsp_t;

    // decoded access handed from the decoder to the read-modify-write stage
    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  elem_width;
        logic        sign_extend;
        logic [1:0]  status;
        logic [5:0]  bit_pos;
        logic [63:0] write_data;
    } acc_ctl_t;

    function automatic logic [63:0] width_mask(input logic [1:0] ew);
        logic [63:0] m;
        case (ew)
            EW_8:    m = 64'h0000_0000_0000_00ff;
            EW_16:   m = 64'h0000_0000_0000_ffff;
            EW_32:   m = 64'h0000_0000_ffff_ffff;
            default: m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

endpackage

FILE: sv/vrea_mem.sv
module vrea_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_data
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/vrea_decode.sv
module vrea_decode #(
    parameter int VLEN_BITS = vrea_pkg::VLEN_BITS_DEFAULT
) (
    input  vrea_pkg::req_t     req,
    output vrea_pkg::acc_ctl_t ctl,
    output logic [$clog2(vrea_pkg::NUM_REGS * (VLEN_BITS / 64))-1:0] addr
);
    import vrea_pkg::*;

    localparam int WPR   = VLEN_BITS / 64;
    localparam int TOTAL = NUM_REGS * WPR;
    localparam int AW    = $clog2(TOTAL);
    // room for the largest base word plus the largest word offset of a group
    localparam int SUM_W = $clog2(TOTAL + 128);
    localparam bit MULTI_WORD = (WPR > 1);

    logic [SUM_W-1:0] base_w;
    logic [SUM_W-1:0] elem_w;
    logic [SUM_W-1:0] mask_w;
    logic [6:0]       group_word;
    logic [5:0]       elem_bit;
    logic             mask_off;
    logic             is_mask;
    logic             misalign;
    logic [4:0]       align_mask;
    logic [1:0]       status;

    assign base_w = SUM_W'(req.reg_num) * SUM_W'(WPR);

    // word within the group and bit offset inside that word
    always_comb
    begin
        unique case (req.elem_width)
            EW_8:
            begin
                group_word = {3'b000, req.elem_index[6:3]};
                elem_bit   = {req.elem_index[2:0], 3'b000};
            end
            EW_16:
            begin
                group_word = {2'b00, req.elem_index[6:2]};
                elem_bit   = {req.elem_index[1:0], 4'b0000};
            end
            EW_32:
            begin
                group_word = {1'b0, req.elem_index[6:1]};
                elem_bit   = {req.elem_index[0], 5'b00000};
            end
            default:
            begin
                group_word = req.elem_index;
                elem_bit   = 6'd0;
            end
        endcase
    end

    assign elem_w   = base_w + SUM_W'(group_word);
    // mask bit index wraps at one register
    assign mask_off = MULTI_WORD ? req.elem_index[6] : 1'b0;
    assign mask_w   = base_w + SUM_W'(mask_off);
    assign is_mask  = (req.mode == MODE_RD_MASK) || (req.mode == MODE_WR_MASK);

    assign align_mask = (5'd1 << req.group_mul[1:0]) - 5'd1;
    assign misalign   = req.check_align && !req.group_mul[2] &&
                        ((req.reg_num & align_mask) != 5'd0);

    always_comb
    begin
        if (is_mask)
        begin
            status = STATUS_OK;
        end
        else if (req.group_mul == GMUL_RESERVED)
        begin
            status = STATUS_RESERVED;
        end
        else if (misalign)
        begin
            status = STATUS_MISALIGN;
        end
        else if (elem_w >= SUM_W'(TOTAL))
        begin
            status = STATUS_PAST_END;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    assign addr = is_mask ? mask_w[AW-1:0] : elem_w[AW-1:0];

    assign ctl.mode        = req.mode;
    assign ctl.elem_width  = req.elem_width;
    assign ctl.sign_extend = req.sign_extend;
    assign ctl.status      = status;
    assign ctl.bit_pos     = is_mask ? req.elem_index[5:0] : elem_bit;
    assign ctl.write_data  = req.write_data;

endmodule

FILE: sv/vector_register_element_access.sv
// response: decode and memory read on the transfer edge, then read-modify-write into the
//   output register once that register is free; rsp_valid rises with that write
// one request at a time: a new request is taken only after the word read and its write-back
// reset: the memory is cleared by a pass over all 32 * VLEN_BITS / 64 words, one word
//   per cycle, with req_stall held high until it completes
module vector_register_element_access #(
    parameter int VLEN_BITS = vrea_pkg::VLEN_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  vrea_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output vrea_pkg::rsp_t rsp
);
    import vrea_pkg::*;

    localparam int WPR   = VLEN_BITS / 64;
    localparam int TOTAL = NUM_REGS * WPR;
    localparam int AW    = $clog2(TOTAL);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_ACCESS = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    acc_ctl_t    ctl_reg, ctl_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg, rsp_next;

    acc_ctl_t    dec_ctl;
    logic [AW-1:0] dec_addr;
    logic        req_xfer;
    logic        finish;
    logic [63:0] word;
    logic [63:0] shifted;
    logic [63:0] wmask;
    logic [63:0] elem;
    logic        sign_bit;
    logic [63:0] result;
    logic [63:0] new_word;
    logic        acc_write;
    logic        mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [63:0] mem_wr_data;

    vrea_decode #(
        .VLEN_BITS(VLEN_BITS)
    ) u_decode (
        .req (req),
        .ctl (dec_ctl),
        .addr(dec_addr)
    );

    vrea_mem #(
        .DEPTH(TOTAL),
        .AW   (AW)
    ) u_mem (
        .clk    (clk),
        .rd_en  (req_xfer),
        .rd_addr(dec_addr),
        .rd_data(word),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    // the access completes once the output register is free or being drained
    assign finish    = (state_reg == ST_ACCESS) && (!rsp_valid_reg || !rsp_stall);

    assign shifted = word >> ctl_reg.bit_pos;
    assign wmask   = width_mask(ctl_reg.elem_width);

    always_comb
    begin
        case (ctl_reg.elem_width)
            EW_8:    sign_bit = shifted[7];
            EW_16:   sign_bit = shifted[15];
            EW_32:   sign_bit = shifted[31];
            default: sign_bit = 1'b0;
        endcase
        elem = shifted & wmask;
        if (ctl_reg.sign_extend && sign_bit)
        begin
            elem = elem | ~wmask;
        end
    end

    always_comb
    begin
        result    = 64'd0;
        new_word  = word;
        acc_write = 1'b0;
        unique case (ctl_reg.mode)
            MODE_RD_ELEM:
            begin
                result = elem;
            end
            MODE_WR_ELEM:
            begin
                new_word  = (word & ~(wmask << ctl_reg.bit_pos)) |
                            ((ctl_reg.write_data & wmask) << ctl_reg.bit_pos);
                acc_write = 1'b1;
            end
            MODE_RD_MASK:
            begin
                result = {63'd0, shifted[0]};
            end
            default:
            begin
                if (ctl_reg.write_data != 64'd0)
                begin
                    new_word = word | (64'd1 << ctl_reg.bit_pos);
                end
                else
                begin
                    new_word = word & ~(64'd1 << ctl_reg.bit_pos);
                end
                acc_write = 1'b1;
            end
        endcase
        // flagged requests read zero and leave the memory alone
        if (ctl_reg.status != STATUS_OK)
        begin
            result    = 64'd0;
            acc_write = 1'b0;
        end
    end

    // clear pass and write-back share the single write port
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_reg;
            mem_wr_data = 64'd0;
        end
        else
        begin
            mem_wr_en   = finish && acc_write;
            mem_wr_addr = addr_reg;
            mem_wr_data = new_word;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        ctl_next       = ctl_reg;
        addr_next      = addr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(TOTAL - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    ctl_next   = dec_ctl;
                    addr_next  = dec_addr;
                    state_next = ST_ACCESS;
                end
            end
            default:
            begin
                if (finish)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.read_data = result;
                    rsp_next.status    = ctl_reg.status;
                    state_next         = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg  <= ctl_next;
        addr_reg <= addr_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/vrea_checker.sv
`include "vector_register_element_access_assert.svh"

module vrea_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input vrea_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input vrea_pkg::rsp_t rsp
);
    import vrea_pkg::*;

    logic req_xfer;
    logic flagged;

    assign req_xfer = req_valid && !req_stall;
    assign flagged  = rsp_valid && (rsp.status != STATUS_OK);

    // a waiting request holds until its transfer
    `VREA_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req), "req moved")

    // a waiting result holds until its transfer
    `VREA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp moved")

    // one request in flight at a time
    `VREA_ASSERT_NEXT(a_one_in_flight, req_xfer, req_stall, "second request taken")

    // a flagged request never returns data
    `VREA_ASSERT_NOW(a_flag_zero, flagged, rsp.read_data == 64'd0, "flagged result carries data")

    // a fresh result follows an earlier request transfer
    `VREA_ASSERT_NOW(a_rsp_from_req, $rose(rsp_valid), $past(req_xfer, 2), "orphan result")

endmodule

bind vector_register_element_access vrea_checker u_vrea_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
);
